/* hdl/assert_macros.svh */
// Assertion macros used by the checker file of the key decoder.
// Depends on nothing; the user supplies clk and arst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion with an explicit clock and active-low reset.
`define ASSERT_CLKD(lbl, ck, rst_n, prop, msg) \
	lbl: assert property (@(posedge ck) disable iff (!rst_n) prop) else $error(msg);

// Clocked assertion on clk, disabled while arst_n is low.
`define ASSERT_DEF(lbl, prop, msg) \
	`ASSERT_CLKD(lbl, clk, arst_n, prop, msg)

`endif

/* hdl/tked_pkg.sv */
// Types, constants and lookup functions of the terminal key decoder.
// Depends on nothing; the burst tracker, decoder, top level and checker import it.
package tked_pkg;

	localparam logic [7:0] ESC_BYTE   = 8'd27;
	localparam logic [7:0] CSI_BYTE   = 8'd91;
	localparam logic [7:0] TILDE_BYTE = 8'd126;
	localparam logic [7:0] SEMI_BYTE  = 8'd59;
	localparam logic [7:0] INTR_BYTE  = 8'd3;
	localparam logic [7:0] BKSP_BYTE  = 8'd8;
	localparam logic [7:0] CR_BYTE    = 8'd13;
	localparam logic [7:0] CTRL_BASE  = 8'd96;
	localparam logic [7:0] ARROW_BASE = 8'd65;
	localparam logic [7:0] DIGIT_ONE  = 8'd49;
	localparam logic [3:0] MAX_BURST  = 4'd7;
	localparam logic [3:0] BURST_SAT  = 4'd8;
	localparam int         STORE_DEPTH = 6;

	typedef enum logic [4:0] {
		KC_ENTER     = 5'd0,
		KC_BACKSPACE = 5'd1,
		KC_ESCAPE    = 5'd2,
		KC_PRINTABLE = 5'd3,
		KC_CONTROL   = 5'd4,
		KC_ALT       = 5'd5,
		KC_UP        = 5'd6,
		KC_DOWN      = 5'd7,
		KC_RIGHT     = 5'd8,
		KC_LEFT      = 5'd9,
		KC_HOME      = 5'd10,
		KC_INSERT    = 5'd11,
		KC_DELETE    = 5'd12,
		KC_END       = 5'd13,
		KC_PGUP      = 5'd14,
		KC_PGDN      = 5'd15,
		KC_FUNCTION  = 5'd16,
		KC_INTERRUPT = 5'd17,
		KC_ERROR     = 5'd18
	} key_code_t;

	typedef struct packed {
		key_code_t   key_code;
		logic [7:0]  key_char;
		logic [2:0]  modifier;
	} key_event_t;

	// Burst status as seen by the decoder for the byte at hand.
	typedef struct packed {
		logic                        collecting;
		logic [3:0]                  count_nxt;
		logic [STORE_DEPTH-1:0][7:0] bytes;
	} burst_view_t;

	// Function key number 1..12 from its two digits, 0 when unknown.
	// The short and long forms disagree on F11 and F12.
	function automatic logic [3:0] fn_num(input logic [7:0] a, input logic [7:0] b,
		input logic long_form);
		logic [3:0] f;
		f = 4'd0;
		if (a == 8'd49) begin
			unique case (b)
				8'd49: f = 4'd1;
				8'd50: f = 4'd2;
				8'd51: f = 4'd3;
				8'd52: f = 4'd4;
				8'd53: f = 4'd5;
				8'd55: f = 4'd6;
				8'd56: f = 4'd7;
				8'd57: f = 4'd8;
				default: f = 4'd0;
			endcase
		end else if (a == 8'd50) begin
			unique case (b)
				8'd48: f = 4'd9;
				8'd49: f = 4'd10;
				8'd51: f = long_form ? 4'd0 : 4'd11;
				8'd52: f = long_form ? 4'd11 : 4'd12;
				8'd53: f = long_form ? 4'd12 : 4'd0;
				default: f = 4'd0;
			endcase
		end
		return f;
	endfunction

endpackage

/* hdl/tked_if.sv */
// Valid/ready channel interfaces for key bytes in and key events out.
// Depends on nothing.
interface tked_key_if;
	logic       valid;
	logic       ready;
	logic [7:0] key_byte;
	logic       burst_end;
	modport source (output valid, key_byte, burst_end, input ready);
	modport sink (input valid, key_byte, burst_end, output ready);
endinterface

interface tked_event_if;
	logic       valid;
	logic       ready;
	logic [4:0] key_code;
	logic [7:0] key_char;
	logic [2:0] modifier;
	modport source (output valid, key_code, key_char, modifier, input ready);
	modport sink (input valid, key_code, key_char, modifier, output ready);
endinterface

/* hdl/tked_burst_track.sv */
// Escape burst state: collecting flag, byte count and stored burst bytes.
// Depends on tked_pkg.
module tked_burst_track (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  advance,
	input  logic [7:0]            key_byte,
	input  logic                  burst_end,
	output tked_pkg::burst_view_t view
);
	import tked_pkg::*;

	logic                        collecting_q;
	logic [3:0]                  count_q;
	logic [STORE_DEPTH-1:0][7:0] bytes_q;
	logic [3:0]                  count_inc;
	logic                        store_en;
	logic [2:0]                  store_idx;

	assign count_inc = (count_q < BURST_SAT) ? count_q + 4'd1 : count_q;
	assign store_en  = collecting_q && count_q >= 4'd1 && count_q <= 4'(STORE_DEPTH);
	assign store_idx = 3'(count_q - 4'd1);

	// The byte at hand is folded into the view so the final byte decodes at once.
	always_comb begin
		view.collecting = collecting_q;
		view.count_nxt  = count_inc;
		for (int i = 0; i < STORE_DEPTH; i++) begin
			view.bytes[i] = (store_en && store_idx == 3'(i)) ? key_byte : bytes_q[i];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			collecting_q <= 1'b0;
			count_q      <= 4'd0;
		end else if (advance) begin
			if (collecting_q) begin
				collecting_q <= !burst_end;
				count_q      <= burst_end ? 4'd0 : count_inc;
			end else if (key_byte == ESC_BYTE && !burst_end) begin
				collecting_q <= 1'b1;
				count_q      <= 4'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (advance && store_en) begin
			bytes_q[store_idx] <= key_byte;
		end
	end

endmodule

/* hdl/tked_decode.sv */
// Combinational key decode of one byte, or of a whole burst at its end.
// Depends on tked_pkg.
module tked_decode (
	input  logic                  [7:0] key_byte,
	input  logic                        burst_end,
	input  tked_pkg::burst_view_t       view,
	output logic                        has_result,
	output tked_pkg::key_event_t        evt
);
	import tked_pkg::*;

	key_event_t  single_evt;
	key_event_t  burst_evt;
	logic        single_hit;
	logic [7:0]  b2, b3, b4, b5, b6, b7;
	logic [3:0]  n;
	logic [3:0]  f_short, f_long;
	logic [7:0]  offs;

	assign n  = view.count_nxt;
	assign b2 = view.bytes[0];
	assign b3 = view.bytes[1];
	assign b4 = view.bytes[2];
	assign b5 = view.bytes[3];
	assign b6 = view.bytes[4];
	assign b7 = view.bytes[5];
	assign f_short = fn_num(b3, b4, 1'b0);
	assign f_long  = fn_num(b3, b4, 1'b1);

	always_comb begin
		burst_evt.key_code = KC_ERROR;
		burst_evt.key_char = 8'd0;
		burst_evt.modifier = 3'd0;
		offs = 8'd0;
		if (n == 4'd2) begin
			burst_evt.key_code = KC_ALT;
			burst_evt.key_char = b2;
		end else if (n <= MAX_BURST && b2 == CSI_BYTE) begin
			if (n == 4'd3) begin
				if (b3 >= ARROW_BASE && b3 <= 8'd68) begin
					offs = b3 - ARROW_BASE;
					burst_evt.key_code = key_code_t'(5'(KC_UP) + offs[4:0]);
				end
			end else if (n == 4'd4) begin
				if (b4 == TILDE_BYTE && b3 >= DIGIT_ONE && b3 <= 8'd54) begin
					offs = b3 - DIGIT_ONE;
					burst_evt.key_code = key_code_t'(5'(KC_HOME) + offs[4:0]);
				end
			end else if (n == 4'd5) begin
				if (b5 == TILDE_BYTE && f_short != 4'd0) begin
					burst_evt.key_code = KC_FUNCTION;
					burst_evt.key_char = {4'd0, f_short};
				end
			end else if (n == 4'd7) begin
				if (b7 == TILDE_BYTE && f_long != 4'd0 && b5 == SEMI_BYTE &&
					b6 >= 8'd50 && b6 <= 8'd54) begin
					offs = b6 - DIGIT_ONE;
					burst_evt.key_code = KC_FUNCTION;
					burst_evt.key_char = {4'd0, f_long};
					burst_evt.modifier = offs[2:0];
				end
			end
		end
	end

	always_comb begin
		single_hit          = 1'b1;
		single_evt.key_code = KC_ERROR;
		single_evt.key_char = 8'd0;
		single_evt.modifier = 3'd0;
		priority if (key_byte == INTR_BYTE) begin
			single_evt.key_code = KC_INTERRUPT;
		end else if (key_byte == BKSP_BYTE) begin
			single_evt.key_code = KC_BACKSPACE;
		end else if (key_byte == CR_BYTE) begin
			single_evt.key_code = KC_ENTER;
		end else if (key_byte >= 8'd32 && key_byte <= TILDE_BYTE) begin
			single_evt.key_code = KC_PRINTABLE;
			single_evt.key_char = key_byte;
		end else if (key_byte >= 8'd1 && key_byte <= 8'd26) begin
			single_evt.key_code = KC_CONTROL;
			single_evt.key_char = CTRL_BASE + key_byte;
		end else if (key_byte == ESC_BYTE) begin
			single_evt.key_code = KC_ESCAPE;
			single_hit          = burst_end;
		end else begin
			single_hit = 1'b0;
		end
	end

	assign has_result = view.collecting ? burst_end : single_hit;
	assign evt        = view.collecting ? burst_evt : single_evt;

endmodule

/* hdl/terminal_key_escape_decoder_unit.sv */
// Terminal key escape decoder: raw keyboard bytes in, decoded key events out.
// An accepted byte passes the input register and then the result register to its event.
// Throughput: one byte per cycle; the input register holds one byte while an event
// waits downstream. Bytes that give no event pass through without a result.
// Reset (arst_n low, asynchronous) clears valids and the burst state; stored burst
// bytes are not reset. Depends on tked_pkg, tked_if, tked_burst_track and tked_decode.
module terminal_key_escape_decoder_unit (
	input logic           clk,
	input logic           arst_n,
	tked_key_if.sink      key_in,
	tked_event_if.source  key_out
);
	import tked_pkg::*;

	// Input stage: one request from the keyboard side.
	logic       valid_s1;
	logic [7:0] key_byte_s1;
	logic       burst_end_s1;

	// Result register toward the consumer.
	logic       out_valid_q;
	key_event_t evt_q;

	logic        advance;
	logic        has_result;
	key_event_t  evt;
	burst_view_t view;

	// The input stage moves on when the result register is free or being
	// drained this cycle. Every byte waits for that, whether or not it gives
	// an event, so a waiting event is never overwritten.
	assign advance      = valid_s1 && (!out_valid_q || key_out.ready);
	assign key_in.ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (key_in.ready) begin
			valid_s1 <= key_in.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (key_in.valid && key_in.ready) begin
			key_byte_s1  <= key_in.key_byte;
			burst_end_s1 <= key_in.burst_end;
		end
	end

	// Burst state advances once per byte leaving the input stage.
	tked_burst_track u_track (
		.clk       (clk),
		.arst_n    (arst_n),
		.advance   (advance),
		.key_byte  (key_byte_s1),
		.burst_end (burst_end_s1),
		.view      (view)
	);

	// Single-byte classification or full burst decode, all in this cycle.
	tked_decode u_decode (
		.key_byte   (key_byte_s1),
		.burst_end  (burst_end_s1),
		.view       (view),
		.has_result (has_result),
		.evt        (evt)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= has_result;
		end else if (key_out.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && has_result) begin
			evt_q <= evt;
		end
	end

	assign key_out.valid    = out_valid_q;
	assign key_out.key_code = 5'(evt_q.key_code);
	assign key_out.key_char = evt_q.key_char;
	assign key_out.modifier = evt_q.modifier;

endmodule

/* hdl/tked_checker.sv */
// Port-level checks of the key decoder, bound to the top level.
// Depends on tked_pkg and assert_macros.svh.
`include "assert_macros.svh"

module tked_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       out_valid,
	input logic       out_ready,
	input logic [4:0] key_code,
	input logic [7:0] key_char,
	input logic [2:0] modifier
);
	import tked_pkg::*;

	// A waiting event must not change until it is taken.
	`ASSERT_DEF(a_out_hold, out_valid && !out_ready |=> out_valid && $stable(key_code) && $stable(key_char) && $stable(modifier), "event changed while stalled")

	// Only function keys carry a modifier.
	`ASSERT_DEF(a_mod_fn_only, out_valid && key_code != 5'(KC_FUNCTION) |-> modifier == 3'd0, "modifier on a non-function key")

	// Function keys are numbered 1..12 with a modifier of at most five.
	`ASSERT_DEF(a_fn_range, out_valid && key_code == 5'(KC_FUNCTION) |-> key_char >= 8'd1 && key_char <= 8'd12 && modifier <= 3'd5, "function key out of range")

	// Errors and keys without a character report zero.
	`ASSERT_DEF(a_err_clean, out_valid && (key_code == 5'(KC_ERROR) || key_code == 5'(KC_ESCAPE) || key_code == 5'(KC_ENTER)) |-> key_char == 8'd0, "stray character")

endmodule

bind terminal_key_escape_decoder_unit tked_checker u_tked_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.out_valid (key_out.valid),
	.out_ready (key_out.ready),
	.key_code  (key_out.key_code),
	.key_char  (key_out.key_char),
	.modifier  (key_out.modifier)
);
